>>> hdl/uxcf_pkg.sv
// ----------------------------------------------------------------------------
// uxcf_pkg
// shared types and constants for the utf-8 xml character filter
// ----------------------------------------------------------------------------
package uxcf_pkg;

  localparam int unsigned MaxGroupBytes = 4;

  // lead byte ranges
  localparam logic [7:0] Lead2Lo = 8'hC2;
  localparam logic [7:0] Lead2Hi = 8'hDF;
  localparam logic [7:0] Lead3Lo = 8'hE0;
  localparam logic [7:0] Lead3Hi = 8'hEF;
  localparam logic [7:0] Lead4Lo = 8'hF0;
  localparam logic [7:0] Lead4Hi = 8'hF4;

  // continuation byte range and the leads that narrow it
  localparam logic [7:0] ContLo      = 8'h80;
  localparam logic [7:0] ContHi      = 8'hBF;
  localparam logic [7:0] LeadE0      = 8'hE0;
  localparam logic [7:0] LeadEd      = 8'hED;
  localparam logic [7:0] LeadF0      = 8'hF0;
  localparam logic [7:0] LeadF4      = 8'hF4;
  localparam logic [7:0] ContLoE0    = 8'hA0;
  localparam logic [7:0] ContHiEd    = 8'h9F;
  localparam logic [7:0] ContLoF0    = 8'h90;
  localparam logic [7:0] ContHiF4    = 8'h8F;
  localparam logic [7:0] NonCharLead = 8'hEF;
  localparam logic [7:0] NonCharMid  = 8'hBF;
  localparam logic [7:0] NonCharLast = 8'hBE;

  // single byte xml characters
  localparam logic [7:0] AsciiLo = 8'h20;
  localparam logic [7:0] AsciiHi = 8'h7F;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;

  // one group of output bytes caused by one input byte
  typedef struct packed {
    logic [MaxGroupBytes-1:0][7:0] data;
    logic [2:0]                    count;   // 0 only for a bare end marker
    logic                          is_last; // carries the end of string
    logic                          clean;   // no byte of the string dropped
  } uxcf_group_t;

endpackage

>>> hdl/uxcf_front.sv
// ----------------------------------------------------------------------------
// uxcf_front
// strict utf-8 decoder: holds partial sequences and forms output groups
// ----------------------------------------------------------------------------
module uxcf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         byte_in_i,
  input  logic               end_of_string_i,
  output logic               push_o,
  output uxcf_pkg::uxcf_group_t group_o
);
  import uxcf_pkg::*;

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      hc_q, hc_d;
  logic [2:0]      len_q, len_d;
  logic            drop_q, drop_d;
  logic [2:0]      n;
  logic            restart;
  logic            fit;
  logic [7:0]      lo, hi;
  logic            drop_fin;

  always_comb begin
    lo = ContLo;
    hi = ContHi;
    if (hc_q == 2'd1) begin
      case (held_q[0])
        LeadE0:  lo = ContLoE0;
        LeadEd:  hi = ContHiEd;
        LeadF0:  lo = ContLoF0;
        LeadF4:  hi = ContHiF4;
        default: ;
      endcase
    end
    fit = (byte_in_i >= lo) && (byte_in_i <= hi);
  end

  always_comb begin
    held_d  = held_q;
    hc_d    = hc_q;
    len_d   = len_q;
    drop_d  = drop_q;
    n       = 3'd0;
    restart = 1'b0;

    if (hc_q == 2'd0) begin
      restart = 1'b1;
    end else if (!fit) begin
      drop_d  = 1'b1;
      hc_d    = 2'd0;
      len_d   = 3'd0;
      restart = 1'b1;
    end else if (({1'b0, hc_q} + 3'd1) < len_q) begin
      held_d[hc_q] = byte_in_i;
      hc_d         = hc_q + 2'd1;
    end else if (len_q == 3'd3 && held_q[0] == NonCharLead &&
                 held_q[1] == NonCharMid && byte_in_i >= NonCharLast) begin
      // u+fffe and u+ffff
      drop_d = 1'b1;
      hc_d   = 2'd0;
      len_d  = 3'd0;
    end else begin
      n     = {1'b0, hc_q} + 3'd1;
      hc_d  = 2'd0;
      len_d = 3'd0;
    end

    if (restart) begin
      if ((byte_in_i >= AsciiLo && byte_in_i <= AsciiHi) || byte_in_i == ChTab ||
          byte_in_i == ChLf || byte_in_i == ChCr) begin
        n = 3'd1;
      end else if (byte_in_i >= Lead2Lo && byte_in_i <= Lead2Hi) begin
        held_d[0] = byte_in_i;
        hc_d      = 2'd1;
        len_d     = 3'd2;
      end else if (byte_in_i >= Lead3Lo && byte_in_i <= Lead3Hi) begin
        held_d[0] = byte_in_i;
        hc_d      = 2'd1;
        len_d     = 3'd3;
      end else if (byte_in_i >= Lead4Lo && byte_in_i <= Lead4Hi) begin
        held_d[0] = byte_in_i;
        hc_d      = 2'd1;
        len_d     = 3'd4;
      end else begin
        drop_d = 1'b1;
      end
    end

    // unfinished sequence at end of string is dropped
    drop_fin = drop_d || (hc_d != 2'd0);

    for (int i = 0; i < 3; i++) begin
      group_o.data[i] = (3'(i + 1) < n) ? held_q[i] : byte_in_i;
    end
    group_o.data[3] = byte_in_i;
    group_o.count   = n;
    group_o.is_last = end_of_string_i;
    group_o.clean   = end_of_string_i && !drop_fin;

    push_o = accept_i && ((n != 3'd0) || end_of_string_i);

    if (end_of_string_i) begin
      held_d = '0;
      hc_d   = 2'd0;
      len_d  = 3'd0;
      drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q   <= 2'd0;
      len_q  <= 3'd0;
      drop_q <= 1'b0;
    end else if (accept_i) begin
      hc_q   <= hc_d;
      len_q  <= len_d;
      drop_q <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

>>> hdl/uxcf_queue.sv
// ----------------------------------------------------------------------------
// uxcf_queue
// small fifo of output groups between decoder and serializer
// ----------------------------------------------------------------------------
module uxcf_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  uxcf_pkg::uxcf_group_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  head_valid_o,
  output uxcf_pkg::uxcf_group_t head_o
);
  import uxcf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  uxcf_group_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/uxcf_back.sv
// ----------------------------------------------------------------------------
// uxcf_back
// serializer: sends the bytes of each group one per transfer
// ----------------------------------------------------------------------------
module uxcf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  uxcf_pkg::uxcf_group_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            byte_out_o,
  output logic                  byte_present_o,
  output logic                  final_result_o,
  output logic                  string_was_clean_o
);
  import uxcf_pkg::*;

  logic [1:0] idx_q;
  logic [1:0] last_idx;
  logic       load, at_last, present;
  logic       valid_q;

  assign last_idx = (head_i.count == 3'd0) ? 2'd0 : 2'(head_i.count - 3'd1);
  assign at_last  = (idx_q == last_idx);
  assign load     = head_valid_i && (!valid_q || !out_stall_i);
  assign pop_o    = load && at_last;
  assign present  = (head_i.count != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_out_o         <= present ? head_i.data[idx_q] : 8'd0;
      byte_present_o     <= present;
      final_result_o     <= head_i.is_last && at_last;
      string_was_clean_o <= head_i.clean && at_last;
    end
  end

  assign out_valid_o = valid_q;

endmodule

>>> hdl/utf8_xml_char_filter.sv
// ----------------------------------------------------------------------------
// utf8_xml_char_filter
// strict utf-8 decoder that passes only legal xml characters
// ----------------------------------------------------------------------------
// Accepts one byte per cycle with an end-of-string mark and returns the bytes
// of every complete, strictly valid utf-8 sequence whose code point is a legal
// xml character; every other byte is dropped. A byte that breaks a held
// sequence drops the held bytes and is then decoded afresh. The last transfer
// of a string has final_result_o set and reports in string_was_clean_o whether
// nothing was dropped; a string whose end produces no byte gives one bare end
// marker (byte_present_o low). Input is taken every cycle while the group
// queue has room (QueueDepth groups); the output side sends one byte per
// transfer, so a group occupies the output register for one transfer per byte,
// and that serializer sets the sustained rate when many multi-byte characters
// complete together. A byte passes the group queue, then the output register.
// ----------------------------------------------------------------------------
module utf8_xml_char_filter #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  input  logic       end_of_string_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic       byte_present_o,
  output logic       final_result_o,
  output logic       string_was_clean_o
);
  import uxcf_pkg::*;

  uxcf_group_t grp, head;
  logic        accept, push, full, pop, head_valid;

  // stall input while the queue cannot take a group
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // decoder: every accepted byte updates the held sequence
  uxcf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .byte_in_i       (byte_in_i),
    .end_of_string_i (end_of_string_i),
    .push_o          (push),
    .group_o         (grp)
  );

  // groups wait here while the serializer drains earlier ones
  uxcf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (grp),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // serializer with output register
  uxcf_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_valid_i       (head_valid),
    .head_i             (head),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .byte_out_o         (byte_out_o),
    .byte_present_o     (byte_present_o),
    .final_result_o     (final_result_o),
    .string_was_clean_o (string_was_clean_o)
  );

endmodule

>>> hdl/uxcf_checker.sv
// ----------------------------------------------------------------------------
// uxcf_checker
// port level checks for the utf-8 xml character filter
// ----------------------------------------------------------------------------
module uxcf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] byte_out_o,
  input logic       byte_present_o,
  input logic       final_result_o,
  input logic       string_was_clean_o
);

  // a stalled output transfer stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  // a stalled output payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(byte_out_o) && $stable(byte_present_o) &&
      $stable(final_result_o) && $stable(string_was_clean_o))
    else $error("output payload changed under stall");

  // a bare marker only ends a string
  a_bare_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_present_o |-> final_result_o && byte_out_o == 8'd0)
    else $error("bare marker without end of string");

  // clean flag only on the last transfer of a string
  a_clean_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_was_clean_o |-> final_result_o)
    else $error("clean flag on non-final transfer");

  // zero bytes never pass
  a_no_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_present_o |-> byte_out_o != 8'd0)
    else $error("zero byte passed through");

endmodule

bind utf8_xml_char_filter uxcf_checker u_uxcf_checker (.*);
